// ===== hw/rtl/gamma_power_law_transform_assert.svh =====
// Assertion macros shared by the gamma transform RTL.
// Both macros expect signals named clk and rst in the including module.
`ifndef GAMMA_POWER_LAW_TRANSFORM_ASSERT_SVH
`define GAMMA_POWER_LAW_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define GPLT_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gplt assertion failed");
`define GPLT_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gplt assertion failed");
`else
`define GPLT_ASSERT_IMP(name, cond, prop)
`define GPLT_ASSERT_NXT(name, cond, prop)
`endif
`endif

// ===== hw/rtl/gplt_pkg.sv =====
// Types, constants and elaboration-time functions for the gamma transform.
// No dependencies.
`default_nettype none
package gplt_pkg;

  localparam int GAIN_W  = 8;
  localparam int EXP_W   = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int LEVEL_W = 16;
  localparam int ZW      = 32;   // log mantissa, Q1.31
  localparam int ZSH_W   = 5;
  localparam int PW      = 32;   // exp2 product, Q.30
  localparam int QP      = 30;

  localparam logic [IDX_W-1:0] REG_GAIN     = 2'd0;
  localparam logic [IDX_W-1:0] REG_EXPONENT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX      = 2'd2;

  // Valid flag and zero-pixel flag travel together down the chain.
  typedef struct packed {
    logic valid;
    logic zero;
  } gplt_tag_t;

  function automatic logic [63:0] gplt_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = v_in;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q.30, by repeated square roots starting from 2.0.
  function automatic logic [PW-1:0] gplt_root(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= k; i++) begin
      r = gplt_isqrt(r << QP);
    end
    return r[PW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gplt_log_cell.sv =====
// One fraction bit of log2 for the pixel and for the maximum level.
// Depends on gplt_pkg.
`default_nettype none
module gplt_log_cell #(
  parameter int FRAC_BITS = 16,
  parameter int EB = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gplt_pkg::gplt_tag_t    in_tag,
  output logic                        in_ready,
  input  wire logic [EB-1:0]          in_er,
  input  wire logic [EB-1:0]          in_em,
  input  wire logic [gplt_pkg::ZW-1:0] in_zr,
  input  wire logic [gplt_pkg::ZW-1:0] in_zm,
  input  wire logic [FRAC_BITS-1:0]   in_fr,
  input  wire logic [FRAC_BITS-1:0]   in_fm,
  output gplt_pkg::gplt_tag_t         out_tag,
  input  wire logic                   out_ready,
  output logic [EB-1:0]               out_er,
  output logic [EB-1:0]               out_em,
  output logic [gplt_pkg::ZW-1:0]     out_zr,
  output logic [gplt_pkg::ZW-1:0]     out_zm,
  output logic [FRAC_BITS-1:0]        out_fr,
  output logic [FRAC_BITS-1:0]        out_fm
);
  import gplt_pkg::*;

  logic            valid;
  logic            zero;
  logic [2*ZW-1:0] sq_r;
  logic [2*ZW-1:0] sq_m;
  logic [ZW:0]     tr;
  logic [ZW:0]     tm;

  assign in_ready = !valid || out_ready;

  // Square the mantissa; a result of two or more yields a one bit.
  always_comb begin
    sq_r = in_zr * in_zr;
    sq_m = in_zm * in_zm;
    tr = sq_r[2*ZW-1:ZW-1];
    tm = sq_m[2*ZW-1:ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      zero   <= in_tag.zero;
      out_er <= in_er;
      out_em <= in_em;
      out_zr <= tr[ZW] ? tr[ZW:1] : tr[ZW-1:0];
      out_zm <= tm[ZW] ? tm[ZW:1] : tm[ZW-1:0];
      out_fr <= {in_fr[FRAC_BITS-2:0], tr[ZW]};
      out_fm <= {in_fm[FRAC_BITS-2:0], tm[ZW]};
    end
  end

  assign out_tag = '{valid: valid, zero: zero};

endmodule
`default_nettype wire

// ===== hw/rtl/gplt_exp_cell.sv =====
// One root multiply of the exp2 chain, taken when its fraction bit is set.
// Depends on gplt_pkg.
`default_nettype none
module gplt_exp_cell #(
  parameter int FRAC_BITS = 16,
  parameter int NW = 10,
  parameter int BIT = 0,
  parameter logic [31:0] ROOT = 32'h4000_0000
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire gplt_pkg::gplt_tag_t     in_tag,
  output logic                         in_ready,
  input  wire logic [gplt_pkg::PW-1:0] in_p,
  input  wire logic [FRAC_BITS-1:0]    in_f,
  input  wire logic [NW-1:0]           in_n,
  output gplt_pkg::gplt_tag_t          out_tag,
  input  wire logic                    out_ready,
  output logic [gplt_pkg::PW-1:0]      out_p,
  output logic [FRAC_BITS-1:0]         out_f,
  output logic [NW-1:0]                out_n
);
  import gplt_pkg::*;

  logic            valid;
  logic            zero;
  logic [2*PW-1:0] prod;

  assign in_ready = !valid || out_ready;
  assign prod = in_p * ROOT;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      zero  <= in_tag.zero;
      out_p <= in_f[BIT] ? prod[QP+PW-1:QP] : in_p;
      out_f <= in_f;
      out_n <= in_n;
    end
  end

  assign out_tag = '{valid: valid, zero: zero};

endmodule
`default_nettype wire

// ===== hw/rtl/gamma_power_law_transform.sv =====
// Gamma power-law transform: s = C * (r/M)^g * M through log2 and exp2.
// Depends on gplt_pkg, gplt_log_cell, gplt_exp_cell and the assertion header.
//
// Usage. Pixels arrive on the input channel (in_valid, in_ready, pixel) and
// transformed levels leave on the output channel (out_valid, out_ready,
// level, clipped). One word moves on a channel when its valid and ready are
// both high at a rising edge. Gain, exponent and max_level are set through
// the write port (cfg_write, cfg_index, cfg_data); the user must write them
// only while no word is in flight, as the block does not enforce it. The
// datapath is a row of 2*FRAC_BITS+4 register stages: a normalizer,
// FRAC_BITS log cells, the exponent multiply, FRAC_BITS exp2 cells, the gain
// multiply and the saturating output register. The first stage loads at the
// edge that takes the pixel, and one pixel per clock is sustained while the
// receiver keeps out_ready high; the rate is set by each cell holding one
// multiplier stage. When the receiver stalls, words pack into empty stages
// first and in_ready drops only once the whole row is full. Reset empties
// the row and loads gain 1, exponent 1.0 and max_level 255.
`default_nettype none
`include "gamma_power_law_transform_assert.svh"
module gamma_power_law_transform #(
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [gplt_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [gplt_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [15:0]                  pixel,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gplt_pkg::LEVEL_W-1:0]      level,
  output logic                              clipped
);
  import gplt_pkg::*;

  localparam int EB     = $clog2(PIXEL_BITS);
  localparam int LOG_W  = EB + FRAC_BITS;
  localparam int D_W    = LOG_W + 1;
  localparam int PR_W   = D_W + EXP_W + 1;
  localparam int Y_W    = PR_W - 12;
  localparam int NW     = Y_W - FRAC_BITS;
  localparam int SH_W   = NW + 1;
  localparam int LIN_W  = FRAC_BITS + 1;
  localparam int GM_W   = GAIN_W + PIXEL_BITS;
  localparam int BASE_W = GM_W + LIN_W;
  localparam int WIDE_W = BASE_W + PIXEL_BITS;
  localparam logic [PIXEL_BITS-1:0] TOP = '1;

  // Configuration registers.
  logic [GAIN_W-1:0] gain;
  logic [EXP_W-1:0]  exponent;
  logic [CFG_W-1:0]  max_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_W'(1);
      exponent  <= EXP_W'(4096);
      max_level <= CFG_W'(255);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN:     gain      <= cfg_data[GAIN_W-1:0];
        REG_EXPONENT: exponent  <= cfg_data[EXP_W-1:0];
        REG_MAX:      max_level <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // The maximum level is normalized combinationally so that a word taken
  // right after a write already sees the new value. The product C*M is
  // only needed at the far end of the row, so it is registered.
  logic [PIXEL_BITS-1:0] m_eff;
  logic [EB-1:0]         em_c;
  logic [EB-1:0]         er_c;
  logic [PIXEL_BITS-1:0] px;
  logic [GM_W-1:0]       gm;

  assign px = pixel[PIXEL_BITS-1:0];

  always_comb begin
    m_eff = (max_level[PIXEL_BITS-1:0] == '0) ? PIXEL_BITS'(1)
                                              : max_level[PIXEL_BITS-1:0];
    em_c = '0;
    er_c = '0;
    for (int i = 0; i < PIXEL_BITS; i++) begin
      if (m_eff[i]) em_c = EB'(i);
      if (px[i])    er_c = EB'(i);
    end
  end

  always_ff @(posedge clk) begin
    gm <= gain * m_eff;
  end

  // Stage 0: leading-one normalization of pixel and maximum level.
  logic            s0_valid;
  logic            s0_zero;
  logic [EB-1:0]   s0_er;
  logic [EB-1:0]   s0_em;
  logic [ZW-1:0]   s0_zr;
  logic [ZW-1:0]   s0_zm;

  gplt_tag_t             lg_tag   [0:FRAC_BITS];
  logic                  lg_ready [0:FRAC_BITS];
  logic [EB-1:0]         lg_er    [0:FRAC_BITS];
  logic [EB-1:0]         lg_em    [0:FRAC_BITS];
  logic [ZW-1:0]         lg_zr    [0:FRAC_BITS];
  logic [ZW-1:0]         lg_zm    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  lg_fr    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  lg_fm    [0:FRAC_BITS];

  assign in_ready = !s0_valid || lg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s0_zero <= (px == '0);
      s0_er   <= er_c;
      s0_em   <= em_c;
      s0_zr   <= ZW'(px) << (ZSH_W'(ZW - 1) - ZSH_W'(er_c));
      s0_zm   <= ZW'(m_eff) << (ZSH_W'(ZW - 1) - ZSH_W'(em_c));
    end
  end

  assign lg_tag[0] = '{valid: s0_valid, zero: s0_zero};
  assign lg_er[0]  = s0_er;
  assign lg_em[0]  = s0_em;
  assign lg_zr[0]  = s0_zr;
  assign lg_zm[0]  = s0_zm;
  assign lg_fr[0]  = '0;
  assign lg_fm[0]  = '0;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_log
    gplt_log_cell #(.FRAC_BITS(FRAC_BITS), .EB(EB)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_tag    (lg_tag[k]),
      .in_ready  (lg_ready[k]),
      .in_er     (lg_er[k]),
      .in_em     (lg_em[k]),
      .in_zr     (lg_zr[k]),
      .in_zm     (lg_zm[k]),
      .in_fr     (lg_fr[k]),
      .in_fm     (lg_fm[k]),
      .out_tag   (lg_tag[k+1]),
      .out_ready (lg_ready[k+1]),
      .out_er    (lg_er[k+1]),
      .out_em    (lg_em[k+1]),
      .out_zr    (lg_zr[k+1]),
      .out_zm    (lg_zm[k+1]),
      .out_fr    (lg_fr[k+1]),
      .out_fm    (lg_fm[k+1])
    );
  end

  // Exponent stage: y = floor(g * (log2 r - log2 M) / 4096), split into an
  // integer part n and a fraction f. Dropping the low product bits of the
  // signed product is the floor.
  logic                 sy_valid;
  logic                 sy_zero;
  logic [NW-1:0]        sy_n;
  logic [FRAC_BITS-1:0] sy_f;
  logic signed [D_W-1:0]  d;
  logic signed [PR_W-1:0] prod_y;

  gplt_tag_t             ex_tag   [0:FRAC_BITS];
  logic                  ex_ready [0:FRAC_BITS];
  logic [PW-1:0]         ex_p     [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  ex_f     [0:FRAC_BITS];
  logic [NW-1:0]         ex_n     [0:FRAC_BITS];

  assign lg_ready[FRAC_BITS] = !sy_valid || ex_ready[0];

  always_comb begin
    d = $signed({1'b0, lg_er[FRAC_BITS], lg_fr[FRAC_BITS]})
      - $signed({1'b0, lg_em[FRAC_BITS], lg_fm[FRAC_BITS]});
    prod_y = $signed({1'b0, exponent}) * d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sy_valid <= 1'b0;
    end else if (lg_ready[FRAC_BITS]) begin
      sy_valid <= lg_tag[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lg_ready[FRAC_BITS]) begin
      sy_zero <= lg_tag[FRAC_BITS].zero;
      sy_n    <= prod_y[PR_W-1:12+FRAC_BITS];
      sy_f    <= prod_y[12+FRAC_BITS-1:12];
    end
  end

  assign ex_tag[0] = '{valid: sy_valid, zero: sy_zero};
  assign ex_p[0]   = PW'(1) << QP;
  assign ex_f[0]   = sy_f;
  assign ex_n[0]   = sy_n;

  // Cell k multiplies by 2^(2^-(k+1)) when fraction bit FRAC_BITS-1-k is set.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_exp
    localparam logic [PW-1:0] RK = gplt_root(k + 1);
    gplt_exp_cell #(
      .FRAC_BITS (FRAC_BITS),
      .NW        (NW),
      .BIT       (FRAC_BITS - 1 - k),
      .ROOT      (RK)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_tag    (ex_tag[k]),
      .in_ready  (ex_ready[k]),
      .in_p      (ex_p[k]),
      .in_f      (ex_f[k]),
      .in_n      (ex_n[k]),
      .out_tag   (ex_tag[k+1]),
      .out_ready (ex_ready[k+1]),
      .out_p     (ex_p[k+1]),
      .out_f     (ex_f[k+1]),
      .out_n     (ex_n[k+1])
    );
  end

  // Gain stage: base = C * M * 2^f, with the shift amount n - FRAC_BITS.
  logic                   sm_valid;
  logic                   sm_zero;
  logic [BASE_W-1:0]      sm_base;
  logic signed [SH_W-1:0] sm_sh;
  logic [LIN_W-1:0]       lin;
  logic                   sm_ready;

  assign lin = LIN_W'(ex_p[FRAC_BITS] >> (QP - FRAC_BITS));
  assign ex_ready[FRAC_BITS] = !sm_valid || sm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (ex_ready[FRAC_BITS]) begin
      sm_valid <= ex_tag[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_ready[FRAC_BITS]) begin
      sm_zero <= ex_tag[FRAC_BITS].zero;
      sm_base <= gm * lin;
      sm_sh   <= $signed({ex_n[FRAC_BITS][NW-1], ex_n[FRAC_BITS]})
               - $signed(SH_W'(FRAC_BITS));
    end
  end

  // Output stage: apply the power-of-two scale and saturate at the top
  // level. A zero pixel gives C*M when the exponent is zero, else zero.
  logic [SH_W-1:0]       sh_mag;
  logic [WIDE_W-1:0]     wide;
  logic [BASE_W-1:0]     shr;
  logic [PIXEL_BITS-1:0] lvl_c;
  logic                  ovf_c;

  assign sm_ready = !out_valid || out_ready;
  assign sh_mag = sm_sh[SH_W-1] ? SH_W'(-sm_sh) : SH_W'(sm_sh);

  always_comb begin
    wide  = WIDE_W'(sm_base) << sh_mag;
    shr   = sm_base >> sh_mag;
    lvl_c = '0;
    ovf_c = 1'b0;
    if (sm_zero) begin
      if (exponent == '0) begin
        ovf_c = (gm >> PIXEL_BITS) != '0;
        lvl_c = gm[PIXEL_BITS-1:0];
      end
    end else if (sm_base != '0) begin
      if (!sm_sh[SH_W-1]) begin
        ovf_c = (sh_mag >= SH_W'(PIXEL_BITS)) || ((wide >> PIXEL_BITS) != '0);
        lvl_c = wide[PIXEL_BITS-1:0];
      end else begin
        ovf_c = (shr >> PIXEL_BITS) != '0;
        lvl_c = shr[PIXEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sm_ready) begin
      out_valid <= sm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_ready) begin
      level   <= LEVEL_W'(ovf_c ? TOP : lvl_c);
      clipped <= ovf_c;
    end
  end

  `GPLT_ASSERT_IMP(a_clip_is_top, out_valid && clipped, level == LEVEL_W'(TOP))
  `GPLT_ASSERT_IMP(a_gain_zero, out_valid && (gain == '0), (level == '0) && !clipped)
  `GPLT_ASSERT_NXT(a_accept_loads, in_valid && in_ready, s0_valid)

endmodule
`default_nettype wire
